// ----- hw/rtl/sync_length_frame_deframer_core_assert.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the sync/length frame deframer
// Shared immediate-consequence and next-cycle property forms.
// ----------------------------------------------------------------------------
`ifndef SYNC_LENGTH_FRAME_DEFRAMER_CORE_ASSERT_SVH
`define SYNC_LENGTH_FRAME_DEFRAMER_CORE_ASSERT_SVH

// The consequence must hold in the same cycle as the antecedent.
`define SLFD_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequence must hold in the cycle after the antecedent.
`define SLFD_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- hw/rtl/slfd_pkg.sv -----
// ----------------------------------------------------------------------------
// slfd_pkg
// Types and codes shared by the sync/length frame deframer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package slfd_pkg;

	localparam int BYTE_W = 8;
	localparam int STATUS_W = 2;
	localparam int POS_W = 6;
	localparam int CFG_IDX_W = 2;

	typedef logic [BYTE_W-1:0] byte_t;
	typedef logic [STATUS_W-1:0] status_t;
	typedef logic [POS_W-1:0] pos_t;
	typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

	// Result status codes.
	localparam status_t STATUS_GOOD = 2'd0;
	localparam status_t STATUS_BAD_CHECK = 2'd1;
	localparam status_t STATUS_TOO_LONG = 2'd2;

	// Configuration register indexes.
	localparam cfg_idx_t CFG_FIRST_SYNC = 2'd0;
	localparam cfg_idx_t CFG_SECOND_SYNC = 2'd1;

	// Register reset values.
	localparam byte_t FIRST_SYNC_RST = 8'hAA;
	localparam byte_t SECOND_SYNC_RST = 8'h55;

endpackage

`default_nettype wire

// ----- hw/rtl/slfd_ram.sv -----
// ----------------------------------------------------------------------------
// slfd_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module slfd_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     wr_en,
	input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
	input  wire logic [WIDTH-1:0]         wr_data,
	input  wire logic                     rd_en,
	input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic      [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

`default_nettype wire

// ----- hw/rtl/sync_length_frame_deframer_core.sv -----
// ----------------------------------------------------------------------------
// sync_length_frame_deframer_core
// Parses sync/type/length/payload/check frames out of a received byte stream.
// ----------------------------------------------------------------------------
// Usage: received bytes arrive on the input channel (in_valid, in_stall,
// rx_byte), one byte per transfer. The block hunts for the two sync bytes set
// in the configuration registers, then takes a type byte, a length byte, the
// payload bytes and an XOR check byte. Each result leaves on the output
// channel (out_valid, out_stall and the result fields) as one transfer.
// A byte that ends no frame is absorbed and gives no result. A good frame with
// payload is replayed from the payload RAM, one result at a time: the read
// state reads the RAM, then the write state loads the output register once
// it is free. in_stall is held high for the whole replay. Error results and
// the empty-packet result come out in the cycle after the byte that caused
// them.
// If the receiver holds out_stall, the output register keeps its result and
// the input is stalled for as long as that result waits, even for bytes that
// would give no result.
// Reset returns the parser to hunting and restores the default sync bytes;
// the payload RAM is not cleared, as only entries written in the current
// frame are ever read back. Configuration writes are applied at once and
// should only be made while the block is idle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sync_length_frame_deframer_core #(
	parameter int MAX_PAYLOAD = 64
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	// Configuration write port
	input  wire logic               cfg_wen,
	input  wire slfd_pkg::cfg_idx_t cfg_index,
	input  wire slfd_pkg::byte_t    cfg_data,
	// Input channel
	input  wire logic               in_valid,
	output logic                    in_stall,
	input  wire slfd_pkg::byte_t    rx_byte,
	// Output channel
	output logic                    out_valid,
	input  wire logic               out_stall,
	output slfd_pkg::status_t       status,
	output slfd_pkg::byte_t         packet_type,
	output slfd_pkg::byte_t         packet_length,
	output logic                    has_data,
	output slfd_pkg::byte_t         data_byte,
	output slfd_pkg::pos_t          byte_position,
	output logic                    last
);

	import slfd_pkg::*;

	`include "sync_length_frame_deframer_core_assert.svh"

	localparam int IDX_W = $clog2(MAX_PAYLOAD);
	localparam int CNT_W = $clog2(MAX_PAYLOAD + 1);
	localparam byte_t MAX_LEN = BYTE_W'(MAX_PAYLOAD);

	// Parser and replay sequencer states.
	localparam logic [2:0] ST_SYNC1 = 3'd0;
	localparam logic [2:0] ST_SYNC2 = 3'd1;
	localparam logic [2:0] ST_TYPE = 3'd2;
	localparam logic [2:0] ST_LENGTH = 3'd3;
	localparam logic [2:0] ST_PAYLOAD = 3'd4;
	localparam logic [2:0] ST_CHECK = 3'd5;
	localparam logic [2:0] ST_RD = 3'd6;
	localparam logic [2:0] ST_WR = 3'd7;

	logic [2:0] state_q, state_d;
	byte_t first_sync_q, second_sync_q;
	byte_t held_type_q, held_type_d;
	byte_t held_length_q, held_length_d;
	logic [CNT_W-1:0] count_q, count_d;
	byte_t check_q, check_d;
	logic [IDX_W-1:0] rep_idx_q, rep_idx_d;

	// Output register.
	logic out_valid_q;
	status_t status_q;
	byte_t type_q, length_q, data_q;
	logic has_data_q, last_q;
	pos_t pos_q;

	// Result that the sequencer presents for loading into the output register.
	typedef struct packed {
		logic    load;
		status_t status;
		byte_t   ptype;
		byte_t   plength;
		logic    has_data;
		byte_t   data;
		pos_t    pos;
		logic    last;
	} result_t;

	result_t res;

	logic out_free;
	logic in_take;
	logic replaying;
	logic rep_last;
	byte_t chk_next;
	logic [CNT_W-1:0] count_inc;
	logic ram_we, ram_re;
	byte_t ram_rdata;

	// The output register can take a new result when empty or being drained.
	assign out_free = !out_valid_q || !out_stall;
	assign replaying = (state_q == ST_RD) || (state_q == ST_WR);
	assign in_stall = replaying || !out_free;
	assign in_take = in_valid && !in_stall;

	// XOR unit for the running check update, shared by the length and payload states.
	assign chk_next = check_q ^ rx_byte;
	assign count_inc = count_q + CNT_W'(1);
	assign rep_last = (BYTE_W'(rep_idx_q) + BYTE_W'(1)) == held_length_q;

	assign ram_we = in_take && (state_q == ST_PAYLOAD);
	assign ram_re = (state_q == ST_RD);

	slfd_ram #(
		.WIDTH(BYTE_W),
		.DEPTH(MAX_PAYLOAD)
	) u_payload_ram (
		.clk     (clk),
		.wr_en   (ram_we),
		.wr_addr (count_q[IDX_W-1:0]),
		.wr_data (rx_byte),
		.rd_en   (ram_re),
		.rd_addr (rep_idx_q),
		.rd_data (ram_rdata)
	);

	always_comb begin
		state_d = state_q;
		held_type_d = held_type_q;
		held_length_d = held_length_q;
		count_d = count_q;
		check_d = check_q;
		rep_idx_d = rep_idx_q;
		res = '0;
		res.ptype = held_type_q;
		res.plength = held_length_q;
		res.last = 1'b1;
		unique case (state_q)
			ST_SYNC1: begin
				if (in_take && (rx_byte == first_sync_q)) begin
					state_d = ST_SYNC2;
				end
			end
			ST_SYNC2: begin
				if (in_take) begin
					state_d = (rx_byte == second_sync_q) ? ST_TYPE : ST_SYNC1;
				end
			end
			ST_TYPE: begin
				if (in_take) begin
					held_type_d = rx_byte;
					check_d = rx_byte;
					state_d = ST_LENGTH;
				end
			end
			ST_LENGTH: begin
				if (in_take) begin
					held_length_d = rx_byte;
					count_d = '0;
					check_d = chk_next;
					if (rx_byte > MAX_LEN) begin
						// Oversized frame: report it and resync.
						res.load = 1'b1;
						res.status = STATUS_TOO_LONG;
						res.plength = rx_byte;
						state_d = ST_SYNC1;
					end else if (rx_byte == '0) begin
						state_d = ST_CHECK;
					end else begin
						state_d = ST_PAYLOAD;
					end
				end
			end
			ST_PAYLOAD: begin
				if (in_take) begin
					count_d = count_inc;
					check_d = chk_next;
					if (BYTE_W'(count_inc) >= held_length_q) begin
						state_d = ST_CHECK;
					end
				end
			end
			ST_CHECK: begin
				if (in_take) begin
					rep_idx_d = '0;
					if (check_q != rx_byte) begin
						res.load = 1'b1;
						res.status = STATUS_BAD_CHECK;
						state_d = ST_SYNC1;
					end else if (held_length_q == '0) begin
						res.load = 1'b1;
						res.status = STATUS_GOOD;
						state_d = ST_SYNC1;
					end else begin
						state_d = ST_RD;
					end
				end
			end
			ST_RD: begin
				state_d = ST_WR;
			end
			ST_WR: begin
				if (out_free) begin
					res.load = 1'b1;
					res.status = STATUS_GOOD;
					res.has_data = 1'b1;
					res.data = ram_rdata;
					res.pos = POS_W'(rep_idx_q);
					res.last = rep_last;
					if (rep_last) begin
						state_d = ST_SYNC1;
					end else begin
						rep_idx_d = rep_idx_q + IDX_W'(1);
						state_d = ST_RD;
					end
				end
			end
			default: begin
				state_d = ST_SYNC1;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_SYNC1;
			first_sync_q <= FIRST_SYNC_RST;
			second_sync_q <= SECOND_SYNC_RST;
			held_type_q <= '0;
			held_length_q <= '0;
			count_q <= '0;
			check_q <= '0;
			rep_idx_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			held_type_q <= held_type_d;
			held_length_q <= held_length_d;
			count_q <= count_d;
			check_q <= check_d;
			rep_idx_q <= rep_idx_d;
			if (cfg_wen) begin
				unique case (cfg_index)
					CFG_FIRST_SYNC: first_sync_q <= cfg_data;
					CFG_SECOND_SYNC: second_sync_q <= cfg_data;
					default: begin
					end
				endcase
			end
			if (out_free) begin
				out_valid_q <= res.load;
			end
		end
	end

	// Result payload: loaded only when a result enters the output register.
	always_ff @(posedge clk) begin
		if (out_free && res.load) begin
			status_q <= res.status;
			type_q <= res.ptype;
			length_q <= res.plength;
			has_data_q <= res.has_data;
			data_q <= res.data;
			pos_q <= res.pos;
			last_q <= res.last;
		end
	end

	assign out_valid = out_valid_q;
	assign status = status_q;
	assign packet_type = type_q;
	assign packet_length = length_q;
	assign has_data = has_data_q;
	assign data_byte = data_q;
	assign byte_position = pos_q;
	assign last = last_q;

	`SLFD_ASSERT_SAME(a_replay_blocks_input, replaying, in_stall,
		"input transfer possible during payload replay")
	`SLFD_ASSERT_SAME(a_replay_idx_in_frame, state_q == ST_WR,
		BYTE_W'(rep_idx_q) < held_length_q,
		"replay index beyond frame length")
	`SLFD_ASSERT_SAME(a_no_data_is_last, out_valid_q && !has_data_q, last_q,
		"result without data is not marked last")
	`SLFD_ASSERT_NEXT(a_last_replay_resyncs,
		(state_q == ST_WR) && out_free && rep_last, state_q == ST_SYNC1,
		"parser did not return to hunting after the last replayed byte")
	`SLFD_ASSERT_SAME(a_ram_write_in_payload, ram_we,
		{1'b0, count_q} < {1'b0, CNT_W'(MAX_PAYLOAD)},
		"payload write beyond the payload RAM")

endmodule

`default_nettype wire
